// ===== src/sfc_pkg.sv =====
package sfc_pkg;

	localparam logic [7:0] HEADER_BYTE       = 8'h16;
	localparam logic [7:0] VALUES_MIN_LENGTH = 8'd15;
	localparam logic [7:0] FRAME_LENGTH_RST  = 8'd56;

	// Value field byte positions within a frame
	localparam logic [7:0] FINE_FIRST   = 8'd3;
	localparam logic [7:0] FINE_LAST    = 8'd6;
	localparam logic [7:0] MEDIUM_FIRST = 8'd7;
	localparam logic [7:0] MEDIUM_LAST  = 8'd10;
	localparam logic [7:0] COARSE_FIRST = 8'd11;
	localparam logic [7:0] COARSE_LAST  = 8'd14;

	typedef struct packed {
		logic        frame_good;
		logic [31:0] fine_mass;
		logic [31:0] medium_mass;
		logic [31:0] coarse_mass;
	} result_t;

	// Handshake between the frame core and the output buffer
	typedef struct packed {
		logic push;
		logic full;
	} buf_ctrl_t;

endpackage

// ===== src/sfc_frame_core.sv =====
module sfc_frame_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                frame_length_we,
	input  logic [7:0]          frame_length_wdata,
	input  logic                accept,
	input  logic [7:0]          rx_byte,
	input  logic                frame_begin,
	output logic                res_valid,
	output sfc_pkg::result_t    res
);

	logic [7:0]  frame_length_q;
	logic [7:0]  byte_position_q;
	logic [7:0]  running_sum_q;
	logic        header_matched_q;
	logic [31:0] fine_q;
	logic [31:0] medium_q;
	logic [31:0] coarse_q;

	logic [7:0]  pos;
	logic [7:0]  last;
	logic        first;
	logic        is_last;
	logic [7:0]  earlier_sum;
	logic        hdr_d;
	logic [31:0] fine_d;
	logic [31:0] medium_d;
	logic [31:0] coarse_d;
	logic        good;
	logic        show;

	always_comb begin
		pos     = frame_begin ? 8'd0 : byte_position_q;
		last    = (frame_length_q < 8'd2) ? 8'd0 : frame_length_q - 8'd1;
		first   = (pos == 8'd0);
		is_last = (pos >= last);

		earlier_sum = first ? 8'd0 : running_sum_q;
		hdr_d       = first ? (rx_byte == sfc_pkg::HEADER_BYTE) : header_matched_q;

		fine_d   = first ? 32'd0 : fine_q;
		medium_d = first ? 32'd0 : medium_q;
		coarse_d = first ? 32'd0 : coarse_q;
		// shift the byte in big-endian into whichever value field owns this position
		if (pos >= sfc_pkg::FINE_FIRST && pos <= sfc_pkg::FINE_LAST) begin
			fine_d = {fine_d[23:0], rx_byte};
		end else if (pos >= sfc_pkg::MEDIUM_FIRST && pos <= sfc_pkg::MEDIUM_LAST) begin
			medium_d = {medium_d[23:0], rx_byte};
		end else if (pos >= sfc_pkg::COARSE_FIRST && pos <= sfc_pkg::COARSE_LAST) begin
			coarse_d = {coarse_d[23:0], rx_byte};
		end

		good = hdr_d && (rx_byte == (8'd0 - earlier_sum));
		show = good && (frame_length_q >= sfc_pkg::VALUES_MIN_LENGTH);

		res_valid       = accept && is_last;
		res.frame_good  = good;
		res.fine_mass   = show ? fine_d : 32'd0;
		res.medium_mass = show ? medium_d : 32'd0;
		res.coarse_mass = show ? coarse_d : 32'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_length_q   <= sfc_pkg::FRAME_LENGTH_RST;
			byte_position_q  <= 8'd0;
			running_sum_q    <= 8'd0;
			header_matched_q <= 1'b0;
			fine_q           <= 32'd0;
			medium_q         <= 32'd0;
			coarse_q         <= 32'd0;
		end else begin
			if (frame_length_we) begin
				frame_length_q <= frame_length_wdata;
			end
			if (accept) begin
				header_matched_q <= hdr_d;
				fine_q           <= fine_d;
				medium_q         <= medium_d;
				coarse_q         <= coarse_d;
				if (is_last) begin
					byte_position_q <= 8'd0;
					running_sum_q   <= 8'd0;
				end else begin
					byte_position_q <= pos + 8'd1;
					running_sum_q   <= earlier_sum + rx_byte;
				end
			end
		end
	end

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |=> (byte_position_q == 8'd0) && (running_sum_q == 8'd0))
		else $error("frame end did not clear position and sum");

	a_mid_advances: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !res_valid |=> byte_position_q != 8'd0)
		else $error("byte position wrapped inside a frame");

	a_short_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (frame_length_q < sfc_pkg::VALUES_MIN_LENGTH)
		|-> (res.fine_mass == 32'd0) && (res.medium_mass == 32'd0)
			&& (res.coarse_mass == 32'd0))
		else $error("short frame reported values");

endmodule

// ===== src/sfc_out_buf.sv =====
module sfc_out_buf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sfc_pkg::buf_ctrl_t   ctrl_in,
	input  sfc_pkg::result_t     res,
	output logic                 full,
	output logic                 out_valid,
	input  logic                 out_stall,
	output sfc_pkg::result_t     out_res
);

	logic             out_valid_q;
	logic             skid_valid_q;
	sfc_pkg::result_t out_q;
	sfc_pkg::result_t skid_q;
	logic             pop;

	assign pop       = out_valid_q && !out_stall;
	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				// no new request enters while the skid stage holds one
				if (pop) begin
					skid_valid_q <= 1'b0;
				end
			end else if (ctrl_in.push) begin
				if (out_valid_q && !pop) begin
					skid_valid_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b1;
				end
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (ctrl_in.push) begin
			if (out_valid_q && !pop) begin
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end
	end

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid stage holds a request with the output empty");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl_in.push && ctrl_in.full))
		else $error("request pushed into a full buffer");

	a_held_request: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q)
		else $error("stalled output request was dropped");

endmodule

// ===== src/sensor_frame_checker.sv =====
// Channel  | Handshake              | Payload
// ---------+------------------------+---------------------------------------------
// input    | in_valid / in_stall    | rx_byte[7:0], frame_begin
// output   | out_valid / out_stall  | frame_good, fine_mass, medium_mass, coarse_mass
// config   | frame_length_we        | frame_length_wdata[7:0]
//
// One byte is accepted per cycle while in_stall is low; a frame's result is registered
// into out_q as its last byte is accepted, or into skid_q when out_q still waits.
// Reset clears position, sum, header flag and values; frame_length returns to 56.
// A two-entry output buffer absorbs stalls: in_stall rises only when both entries
// hold undelivered results, so bytes keep flowing while one result waits.
module sensor_frame_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        frame_length_we,
	input  logic [7:0]  frame_length_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        frame_begin,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        frame_good,
	output logic [31:0] fine_mass,
	output logic [31:0] medium_mass,
	output logic [31:0] coarse_mass
);

	logic               accept;
	logic               res_valid;
	logic               full;
	sfc_pkg::result_t   res;
	sfc_pkg::result_t   out_res;
	sfc_pkg::buf_ctrl_t ctrl;

	assign in_stall = full;
	assign accept   = in_valid && !full;

	assign ctrl.push = res_valid;
	assign ctrl.full = full;

	sfc_frame_core u_core (
		.clk                (clk),
		.arst_n             (arst_n),
		.frame_length_we    (frame_length_we),
		.frame_length_wdata (frame_length_wdata),
		.accept             (accept),
		.rx_byte            (rx_byte),
		.frame_begin        (frame_begin),
		.res_valid          (res_valid),
		.res                (res)
	);

	sfc_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl_in   (ctrl),
		.res       (res),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res)
	);

	assign frame_good  = out_res.frame_good;
	assign fine_mass   = out_res.fine_mass;
	assign medium_mass = out_res.medium_mass;
	assign coarse_mass = out_res.coarse_mass;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

	localparam int LIMIT_CYCLES = 300000;
	localparam int DRAIN_CYCLES = 6;
	localparam int RANDOM_BYTES = 560;

	typedef enum bit {ROW_BYTE, ROW_LENGTH} row_kind_t;

	typedef struct {
		row_kind_t        kind;
		logic [7:0]       value;
		logic             begin_flag;
		bit               fixed;
		sfc_pkg::result_t want;
	} dir_row_t;

	localparam sfc_pkg::result_t SHORT_GOOD = '{1'b1, 32'd0, 32'd0, 32'd0};
	localparam sfc_pkg::result_t REJECTED   = '{1'b0, 32'd0, 32'd0, 32'd0};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        frame_length_we = 1'b0;
	logic [7:0]  frame_length_wdata = 8'd0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte = 8'd0;
	logic        frame_begin = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        frame_good;
	logic [31:0] fine_mass;
	logic [31:0] medium_mass;
	logic [31:0] coarse_mass;

	// Predictor state
	logic [7:0]  model_len = sfc_pkg::FRAME_LENGTH_RST;
	logic [7:0]  model_pos = 8'd0;
	logic [7:0]  model_sum = 8'd0;
	logic        model_header_ok = 1'b0;
	logic [31:0] model_fine = 32'd0;
	logic [31:0] model_medium = 32'd0;
	logic [31:0] model_coarse = 32'd0;

	sfc_pkg::result_t awaited_results [$];
	int      bytes_taken = 0;
	int      byte_count = 0;
	int      result_count = 0;
	int      fail_count = 0;
	int      stall_run = 0;
	int      cycle_count = 0;
	bit      steady = 1'b0;
	bit      stall_off = 1'b0;

	dir_row_t directed_rows [0:28] = '{
		// header with no begin flag right after reset, then shorten the frame under it
		'{ROW_BYTE,   8'h16, 1'b0, 1'b0, REJECTED},
		'{ROW_BYTE,   8'h05, 1'b0, 1'b0, REJECTED},
		'{ROW_LENGTH, 8'd2,  1'b0, 1'b0, REJECTED},
		'{ROW_BYTE,   8'hE5, 1'b0, 1'b1, SHORT_GOOD},
		'{ROW_BYTE,   8'h16, 1'b0, 1'b0, REJECTED},
		'{ROW_BYTE,   8'hEA, 1'b0, 1'b1, SHORT_GOOD},
		// checksum right, header wrong
		'{ROW_BYTE,   8'h17, 1'b1, 1'b0, REJECTED},
		'{ROW_BYTE,   8'hE9, 1'b0, 1'b1, REJECTED},
		'{ROW_LENGTH, 8'd0,  1'b0, 1'b0, REJECTED},
		'{ROW_BYTE,   8'h00, 1'b1, 1'b1, REJECTED},
		'{ROW_BYTE,   8'h16, 1'b0, 1'b1, REJECTED},
		'{ROW_LENGTH, 8'd1,  1'b0, 1'b0, REJECTED},
		'{ROW_BYTE,   8'hFF, 1'b1, 1'b1, REJECTED},
		// shortest frame that carries the three values
		'{ROW_LENGTH, 8'd15, 1'b0, 1'b0, REJECTED},
		'{ROW_BYTE,   8'h16, 1'b1, 1'b0, REJECTED},
		'{ROW_BYTE,   8'h00, 1'b0, 1'b0, REJECTED},
		'{ROW_BYTE,   8'h00, 1'b0, 1'b0, REJECTED},
		'{ROW_BYTE,   8'hFF, 1'b0, 1'b0, REJECTED},
		'{ROW_BYTE,   8'h00, 1'b0, 1'b0, REJECTED},
		'{ROW_BYTE,   8'h80, 1'b0, 1'b0, REJECTED},
		'{ROW_BYTE,   8'h01, 1'b0, 1'b0, REJECTED},
		'{ROW_BYTE,   8'h12, 1'b0, 1'b0, REJECTED},
		'{ROW_BYTE,   8'h34, 1'b0, 1'b0, REJECTED},
		'{ROW_BYTE,   8'h56, 1'b0, 1'b0, REJECTED},
		'{ROW_BYTE,   8'h78, 1'b0, 1'b0, REJECTED},
		'{ROW_BYTE,   8'hDE, 1'b0, 1'b0, REJECTED},
		'{ROW_BYTE,   8'hAD, 1'b0, 1'b0, REJECTED},
		'{ROW_BYTE,   8'hBE, 1'b0, 1'b0, REJECTED},
		'{ROW_BYTE,   8'h0D, 1'b0, 1'b0, REJECTED}
	};

	sensor_frame_checker u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.frame_length_we   (frame_length_we),
		.frame_length_wdata(frame_length_wdata),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.rx_byte           (rx_byte),
		.frame_begin       (frame_begin),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.frame_good        (frame_good),
		.fine_mass         (fine_mass),
		.medium_mass       (medium_mass),
		.coarse_mass       (coarse_mass)
	);

	always #6 clk = ~clk;

	// Advance the frame tracker by one byte; returns 1 when the byte closes a frame.
	function automatic bit track_byte(input logic [7:0] b, input logic bgn,
			output sfc_pkg::result_t res);
		logic [7:0] pos;
		logic [7:0] last;
		logic [7:0] earlier;
		logic [7:0] check;
		logic       good;
		logic       show;
		pos = bgn ? 8'd0 : model_pos;
		last = (model_len < 8'd2) ? 8'd0 : model_len - 8'd1;
		res = '0;
		if (pos == 8'd0) begin
			model_header_ok = (b == sfc_pkg::HEADER_BYTE);
			model_fine = 32'd0;
			model_medium = 32'd0;
			model_coarse = 32'd0;
			earlier = 8'd0;
		end else begin
			earlier = model_sum;
		end
		if (pos >= sfc_pkg::FINE_FIRST && pos <= sfc_pkg::FINE_LAST) begin
			model_fine = {model_fine[23:0], b};
		end else if (pos >= sfc_pkg::MEDIUM_FIRST && pos <= sfc_pkg::MEDIUM_LAST) begin
			model_medium = {model_medium[23:0], b};
		end else if (pos >= sfc_pkg::COARSE_FIRST && pos <= sfc_pkg::COARSE_LAST) begin
			model_coarse = {model_coarse[23:0], b};
		end
		if (pos >= last) begin
			check = 8'd0 - earlier;
			good = model_header_ok && (b == check);
			show = good && (model_len >= sfc_pkg::VALUES_MIN_LENGTH);
			res.frame_good = good;
			res.fine_mass = show ? model_fine : 32'd0;
			res.medium_mass = show ? model_medium : 32'd0;
			res.coarse_mass = show ? model_coarse : 32'd0;
			model_sum = 8'd0;
			model_pos = 8'd0;
			return 1'b1;
		end
		model_sum = earlier + b;
		model_pos = pos + 8'd1;
		return 1'b0;
	endfunction

	// Hold the request until it is taken; leaves us on the falling edge after the take.
	task automatic push_byte(input logic [7:0] b, input logic bgn, input bit fixed,
			input sfc_pkg::result_t want);
		sfc_pkg::result_t predicted;
		int               target;
		if (track_byte(b, bgn, predicted)) begin
			awaited_results.push_back(fixed ? want : predicted);
			result_count++;
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		frame_begin <= bgn;
		target = bytes_taken + 1;
		do @(negedge clk); while (bytes_taken < target);
		byte_count++;
	endtask

	task automatic rest();
		int n;
		int pick;
		pick = $urandom_range(0, 99);
		if (steady || pick < 60)
			n = 0;
		else if (pick < 94)
			n = $urandom_range(1, 3);
		else
			n = $urandom_range(8, 40);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input logic bgn);
		push_byte(b, bgn, 1'b0, REJECTED);
		rest();
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (awaited_results.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_length(input logic [7:0] v);
		frame_length_we <= 1'b1;
		frame_length_wdata <= v;
		@(negedge clk);
		frame_length_we <= 1'b0;
		model_len = v;
	endtask

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	// Mostly well-formed frames; some with a bad checksum, a bad header or cut short.
	task automatic send_frame(input logic [7:0] len);
		int         n;
		int         style;
		logic [7:0] b;
		logic [7:0] sum;
		logic       bgn;
		n = (len < 8'd2) ? 1 : int'(len);
		style = $urandom_range(0, 9);
		if (style == 9 && n > 1)
			n = $urandom_range(1, n - 1);
		sum = 8'd0;
		for (int i = 0; i < n; i++) begin
			bgn = 1'b0;
			if (i == 0) begin
				b = (style == 8) ? pick_byte() : sfc_pkg::HEADER_BYTE;
				bgn = ($urandom_range(0, 3) != 0);
			end else if (i == n - 1 && style < 7) begin
				b = 8'd0 - sum;
			end else begin
				b = pick_byte();
			end
			sum = sum + b;
			send_byte(b, bgn);
		end
	endtask

	always @(negedge clk) begin
		if (!arst_n || stall_off) begin
			out_stall <= 1'b0;
		end else if (stall_run > 0) begin
			out_stall <= 1'b1;
			stall_run--;
		end else begin
			int pick;
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				out_stall <= 1'b0;
			end else begin
				stall_run = (pick < 96) ? $urandom_range(0, 2) : $urandom_range(10, 40);
				out_stall <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		sfc_pkg::result_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (awaited_results.size() == 0) begin
					$error("unexpected result: good %0d fine %h medium %h coarse %h",
						frame_good, fine_mass, medium_mass, coarse_mass);
					fail_count++;
				end else begin
					want = awaited_results.pop_front();
					if (frame_good !== want.frame_good) begin
						$error("frame_good: expected %0d, got %0d", want.frame_good, frame_good);
						fail_count++;
					end
					if (fine_mass !== want.fine_mass) begin
						$error("fine_mass: expected %h, got %h", want.fine_mass, fine_mass);
						fail_count++;
					end
					if (medium_mass !== want.medium_mass) begin
						$error("medium_mass: expected %h, got %h", want.medium_mass, medium_mass);
						fail_count++;
					end
					if (coarse_mass !== want.coarse_mass) begin
						$error("coarse_mass: expected %h, got %h", want.coarse_mass, coarse_mass);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall)
				bytes_taken++;
		end
	end

	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("simulation failed");
		$finish;
	end

	initial begin
		logic [7:0] len;
		int         frames;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_LENGTH) begin
				wait_idle();
				write_length(directed_rows[i].value);
			end else begin
				push_byte(directed_rows[i].value, directed_rows[i].begin_flag,
					directed_rows[i].fixed, directed_rows[i].want);
				rest();
			end
		end

		// one frame at the longest length
		wait_idle();
		write_length(8'd255);
		send_frame(8'd255);

		while (byte_count < $size(directed_rows) + RANDOM_BYTES) begin
			wait_idle();
			case ($urandom_range(0, 19))
				0: len = 8'($urandom_range(0, 1));
				1: len = 8'd2;
				2: len = 8'd14;
				3: len = sfc_pkg::VALUES_MIN_LENGTH;
				4: len = 8'd16;
				default: len = 8'($urandom_range(2, 32));
			endcase
			write_length(len);
			steady = ($urandom_range(0, 3) == 0);
			stall_off = ($urandom_range(0, 3) == 0);
			frames = $urandom_range(2, 8);
			repeat (frames) begin
				// stray bytes between frames
				if ($urandom_range(0, 5) == 0) begin
					repeat ($urandom_range(1, 4))
						send_byte(pick_byte(), 1'($urandom_range(0, 1)));
				end
				send_frame(len);
			end
		end

		wait_idle();
		if (fail_count == 0 && awaited_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/sfc_pkg.sv
src/sfc_frame_core.sv
src/sfc_out_buf.sv
src/sensor_frame_checker.sv
test/testbench.sv
